/* hw/rtl/pbmb_pkg.sv */
// Shared types and constants of the banked memory bus.
// Used by pbmb_decode and pla_banked_memory_bus; depends on nothing.
package pbmb_pkg;

    // Request types.
    localparam logic [2:0] REQ_READ     = 3'd0;
    localparam logic [2:0] REQ_WRITE    = 3'd1;
    localparam logic [2:0] REQ_ROM_LOAD = 3'd2;
    localparam logic [2:0] REQ_KEY_COL  = 3'd3;
    localparam logic [2:0] REQ_TICK     = 3'd4;
    localparam logic [2:0] REQ_IRQ_ACK  = 3'd5;

    // ROM load targets.
    localparam logic [2:0] ROM_BASIC     = 3'd0;
    localparam logic [2:0] ROM_KERNEL    = 3'd1;
    localparam logic [2:0] ROM_CHARSET   = 3'd2;
    localparam logic [2:0] ROM_CART_LOW  = 3'd3;
    localparam logic [2:0] ROM_CART_HIGH = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_EXROM_INACTIVE    = 3'd0;
    localparam logic [2:0] CFG_GAME_INACTIVE     = 3'd1;
    localparam logic [2:0] CFG_BASIC_PRESENT     = 3'd2;
    localparam logic [2:0] CFG_KERNEL_PRESENT    = 3'd3;
    localparam logic [2:0] CFG_CHARSET_PRESENT   = 3'd4;
    localparam logic [2:0] CFG_CART_LOW_PRESENT  = 3'd5;
    localparam logic [2:0] CFG_CART_HIGH_PRESENT = 3'd6;

    // Source of the read data.
    localparam logic [3:0] SRC_ZERO   = 4'd0;
    localparam logic [3:0] SRC_LOCAL  = 4'd1;
    localparam logic [3:0] SRC_RAM    = 4'd2;
    localparam logic [3:0] SRC_COLOR  = 4'd3;
    localparam logic [3:0] SRC_BASIC  = 4'd4;
    localparam logic [3:0] SRC_KERNEL = 4'd5;
    localparam logic [3:0] SRC_CHAR   = 4'd6;
    localparam logic [3:0] SRC_CARTL  = 4'd7;
    localparam logic [3:0] SRC_CARTH  = 4'd8;

    // Locally decoded locations in the map: constants and I/O registers.
    localparam logic [2:0] LOC_ZERO   = 3'd0;
    localparam logic [2:0] LOC_FF     = 3'd1;
    localparam logic [2:0] LOC_COLSEL = 3'd2;
    localparam logic [2:0] LOC_KEYS   = 3'd3;
    localparam logic [2:0] LOC_FLAGS  = 3'd4;
    localparam logic [2:0] LOC_PDIR   = 3'd5;
    localparam logic [2:0] LOC_PVAL   = 3'd6;

    // Keyboard port register numbers.
    localparam logic [3:0] KREG_COLSEL = 4'h0;
    localparam logic [3:0] KREG_ROWS   = 4'h1;
    localparam logic [3:0] KREG_RAM_A  = 4'h2;
    localparam logic [3:0] KREG_RAM_B  = 4'h3;
    localparam logic [3:0] KREG_FLAGS  = 4'hD;

    localparam logic [7:0] KEY_PAGE   = 8'hDC;
    localparam logic [7:0] PORT2_PAGE = 8'hDD;

    localparam logic [7:0] PORT_DIR_RST = 8'h2F;
    localparam logic [7:0] PORT_VAL_RST = 8'h37;
    localparam logic [7:0] IRQ_FLAG_SET = 8'h81;
    localparam logic [7:0] COLOR_HIGH   = 8'hF0;

    localparam int TIMER_W = 16;
    localparam logic [TIMER_W-1:0] TIMER_RELOAD = 16'd17045;

    localparam int KEY_COLS = 8;

    typedef struct packed {
        logic exrom_inactive;
        logic game_inactive;
        logic basic_present;
        logic kernel_present;
        logic charset_present;
        logic cart_low_present;
        logic cart_high_present;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  rd_src;
        logic [2:0]  loc_sel;
        logic [15:0] ram_addr;
        logic        wr_ram;
        logic        wr_color;
    } t_map;

endpackage

/* hw/rtl/pla_banked_memory_bus.sv */
// Banked memory bus: top level with RAM, color store, ROM images and I/O registers.
// Depends on pbmb_pkg, pbmb_ram and pbmb_decode.
//
// The block takes one item per clock cycle while o_in_ready is high and delivers the
// result through a read stage and an output register, so a stalled consumer holds at
// most two items in flight. All memory writes and register updates happen at the edge
// of the input transfer; each memory is a single-port synchronous RAM with registered
// read data, which forms the read stage. RAM, color and ROM image contents are
// undefined until written. Configuration writes take effect at once and are expected
// only while the block is idle.
module pla_banked_memory_bus (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [2:0]  i_rom_select,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [2:0]  i_key_column,
    input  logic [5:0]  i_tick_cycles,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_irq_pending,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [0:0]  i_cfg_data
);
    import pbmb_pkg::*;

    t_cfg               r_cfg;
    t_map               map;
    logic [7:0]         r_port_dir;
    logic [7:0]         r_port_val;
    logic [7:0]         r_key_rows [KEY_COLS];
    logic [7:0]         r_col_sel;
    logic [7:0]         r_int_flags;
    logic [TIMER_W-1:0] r_timer;
    logic               r_irq_line;

    logic               r_s1_vld;
    logic [3:0]         r_s1_src;
    logic [7:0]         r_s1_local;
    logic               r_s1_irq;
    logic               r_out_vld;
    logic [7:0]         r_out_data;
    logic               r_out_irq;

    logic               accept;
    logic               s1_move;
    logic               is_read;
    logic               is_write;
    logic               is_load;
    logic [7:0]         keys_and;
    logic [7:0]         local_val;
    logic [7:0]         n_int_flags;
    logic [TIMER_W-1:0] n_timer;
    logic               n_irq_line;
    logic [TIMER_W:0]   timer_diff;
    logic [TIMER_W:0]   timer_sum;
    logic               timer_expire;
    logic [3:0]         n_s1_src;
    logic [7:0]         s1_data;
    logic               img_in_range;

    logic [7:0]         ram_rdata;
    logic [3:0]         color_rdata;
    logic [7:0]         basic_rdata;
    logic [7:0]         kernel_rdata;
    logic [7:0]         char_rdata;
    logic [7:0]         cartl_rdata;
    logic [7:0]         carth_rdata;

    assign s1_move    = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_move;
    assign accept     = i_in_valid && o_in_ready;
    assign is_read    = accept && (i_req_type == REQ_READ);
    assign is_write   = accept && (i_req_type == REQ_WRITE);
    assign is_load    = accept && (i_req_type == REQ_ROM_LOAD);
    assign img_in_range = (i_address[15:13] == 3'b000);

    pbmb_decode u_decode (
        .i_addr (i_address),
        .i_bank (r_port_val[2:0]),
        .i_cfg  (r_cfg),
        .o_map  (map)
    );

    pbmb_ram #(.ADDR_W(16), .DATA_W(8)) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (is_write && map.wr_ram),
        .i_re    (is_read),
        .i_addr  (map.ram_addr),
        .i_wdata (i_write_data),
        .o_rdata (ram_rdata)
    );

    pbmb_ram #(.ADDR_W(10), .DATA_W(4)) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (is_write && map.wr_color),
        .i_re    (is_read),
        .i_addr  (i_address[9:0]),
        .i_wdata (i_write_data[3:0]),
        .o_rdata (color_rdata)
    );

    pbmb_ram #(.ADDR_W(13), .DATA_W(8)) u_basic_rom (
        .i_clk   (i_clk),
        .i_we    (is_load && (i_rom_select == ROM_BASIC) && img_in_range),
        .i_re    (is_read),
        .i_addr  (i_address[12:0]),
        .i_wdata (i_write_data),
        .o_rdata (basic_rdata)
    );

    pbmb_ram #(.ADDR_W(13), .DATA_W(8)) u_kernel_rom (
        .i_clk   (i_clk),
        .i_we    (is_load && (i_rom_select == ROM_KERNEL) && img_in_range),
        .i_re    (is_read),
        .i_addr  (i_address[12:0]),
        .i_wdata (i_write_data),
        .o_rdata (kernel_rdata)
    );

    pbmb_ram #(.ADDR_W(12), .DATA_W(8)) u_char_rom (
        .i_clk   (i_clk),
        .i_we    (is_load && (i_rom_select == ROM_CHARSET) && (i_address[15:12] == 4'h0)),
        .i_re    (is_read),
        .i_addr  (i_address[11:0]),
        .i_wdata (i_write_data),
        .o_rdata (char_rdata)
    );

    pbmb_ram #(.ADDR_W(13), .DATA_W(8)) u_cartl_rom (
        .i_clk   (i_clk),
        .i_we    (is_load && (i_rom_select == ROM_CART_LOW) && img_in_range),
        .i_re    (is_read),
        .i_addr  (i_address[12:0]),
        .i_wdata (i_write_data),
        .o_rdata (cartl_rdata)
    );

    pbmb_ram #(.ADDR_W(13), .DATA_W(8)) u_carth_rom (
        .i_clk   (i_clk),
        .i_we    (is_load && (i_rom_select == ROM_CART_HIGH) && img_in_range),
        .i_re    (is_read),
        .i_addr  (i_address[12:0]),
        .i_wdata (i_write_data),
        .o_rdata (carth_rdata)
    );

    always_comb begin
        keys_and = 8'hFF;
        for (int i = 0; i < KEY_COLS; i++) begin
            if (!r_col_sel[i]) begin
                keys_and = keys_and & r_key_rows[i];
            end
        end
    end

    always_comb begin
        case (map.loc_sel)
            LOC_FF:     local_val = 8'hFF;
            LOC_COLSEL: local_val = 8'hFF;
            LOC_KEYS:   local_val = keys_and;
            LOC_FLAGS:  local_val = r_int_flags;
            LOC_PDIR:   local_val = r_port_dir;
            LOC_PVAL:   local_val = r_port_val;
            default:    local_val = 8'h00;
        endcase
    end

    assign timer_diff   = {1'b0, r_timer} - {{(TIMER_W - 5){1'b0}}, i_tick_cycles};
    assign timer_sum    = timer_diff + {1'b0, TIMER_RELOAD};
    assign timer_expire = timer_diff[TIMER_W] || (timer_diff == '0);

    always_comb begin
        n_int_flags = r_int_flags;
        n_timer     = r_timer;
        n_irq_line  = r_irq_line;
        n_s1_src    = SRC_ZERO;
        if (accept) begin
            case (i_req_type)
                REQ_READ: begin
                    n_s1_src = map.rd_src;
                    if (map.rd_src == SRC_LOCAL && map.loc_sel == LOC_FLAGS) begin
                        n_int_flags = 8'h00;
                    end
                end
                REQ_TICK: begin
                    if (timer_expire) begin
                        n_timer     = timer_sum[TIMER_W-1:0];
                        n_int_flags = r_int_flags | IRQ_FLAG_SET;
                        n_irq_line  = 1'b1;
                    end else begin
                        n_timer = timer_diff[TIMER_W-1:0];
                    end
                end
                REQ_IRQ_ACK: begin
                    n_irq_line = 1'b0;
                end
                default: begin
                    n_s1_src = SRC_ZERO;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{exrom_inactive: 1'b1, game_inactive: 1'b1, default: 1'b0};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXROM_INACTIVE:    r_cfg.exrom_inactive    <= i_cfg_data[0];
                CFG_GAME_INACTIVE:     r_cfg.game_inactive     <= i_cfg_data[0];
                CFG_BASIC_PRESENT:     r_cfg.basic_present     <= i_cfg_data[0];
                CFG_KERNEL_PRESENT:    r_cfg.kernel_present    <= i_cfg_data[0];
                CFG_CHARSET_PRESENT:   r_cfg.charset_present   <= i_cfg_data[0];
                CFG_CART_LOW_PRESENT:  r_cfg.cart_low_present  <= i_cfg_data[0];
                CFG_CART_HIGH_PRESENT: r_cfg.cart_high_present <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_dir  <= PORT_DIR_RST;
            r_port_val  <= PORT_VAL_RST;
            r_col_sel   <= 8'h00;
            r_int_flags <= 8'h00;
            r_timer     <= TIMER_RELOAD;
            r_irq_line  <= 1'b0;
            for (int i = 0; i < KEY_COLS; i++) begin
                r_key_rows[i] <= 8'hFF;
            end
        end else begin
            r_int_flags <= n_int_flags;
            r_timer     <= n_timer;
            r_irq_line  <= n_irq_line;
            if (is_write && map.rd_src == SRC_LOCAL) begin
                case (map.loc_sel)
                    LOC_PDIR:   r_port_dir <= i_write_data;
                    LOC_PVAL:   r_port_val <= i_write_data;
                    LOC_COLSEL: r_col_sel  <= i_write_data;
                    default: begin
                    end
                endcase
            end
            if (accept && i_req_type == REQ_KEY_COL) begin
                r_key_rows[i_key_column] <= i_write_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_src   <= n_s1_src;
            r_s1_local <= local_val;
            r_s1_irq   <= n_irq_line;
        end
    end

    always_comb begin
        case (r_s1_src)
            SRC_LOCAL:  s1_data = r_s1_local;
            SRC_RAM:    s1_data = ram_rdata;
            SRC_COLOR:  s1_data = {4'h0, color_rdata} | COLOR_HIGH;
            SRC_BASIC:  s1_data = basic_rdata;
            SRC_KERNEL: s1_data = kernel_rdata;
            SRC_CHAR:   s1_data = char_rdata;
            SRC_CARTL:  s1_data = cartl_rdata;
            SRC_CARTH:  s1_data = carth_rdata;
            default:    s1_data = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= s1_data;
            r_out_irq  <= r_s1_irq;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_read_data   = r_out_data;
    assign o_irq_pending = r_out_irq;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_move |=> r_s1_vld && $stable(r_s1_src) && $stable(r_s1_local))
        else $error("read stage lost or changed a stalled item");

    a_irq_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req_type == REQ_IRQ_ACK |=> !r_irq_line)
        else $error("interrupt acknowledge did not clear the line");

    a_flag_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_read && map.rd_src == SRC_LOCAL && map.loc_sel == LOC_FLAGS |=> r_int_flags == 8'h00)
        else $error("interrupt flags not cleared by their read");

    a_timer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer != '0 && r_timer <= TIMER_RELOAD)
        else $error("timer count outside its reload range");

    a_irq_sets_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req_type == REQ_TICK && timer_expire |=> r_irq_line && r_int_flags[7]
        && r_int_flags[0])
        else $error("timer expiry did not raise the interrupt");

endmodule

/* hw/rtl/pbmb_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module pbmb_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);
    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/pbmb_decode.sv */
// Address decoder of the banked memory map: banking bits and cartridge lines.
// Depends on pbmb_pkg.
module pbmb_decode (
    input  logic [15:0]     i_addr,
    input  logic [2:0]      i_bank,
    input  pbmb_pkg::t_cfg  i_cfg,
    output pbmb_pkg::t_map  o_map
);
    import pbmb_pkg::*;

    logic       lo_on;
    logic       hi_on;
    logic       ch_on;
    logic       roml;
    logic       romh;
    logic       io_on;
    logic [3:0] reg_num;

    assign lo_on   = i_bank[0];
    assign hi_on   = i_bank[1];
    assign ch_on   = i_bank[2];
    assign roml    = !i_cfg.exrom_inactive && i_cfg.cart_low_present;
    assign romh    = !i_cfg.exrom_inactive && !i_cfg.game_inactive && i_cfg.cart_high_present;
    assign io_on   = ch_on && (lo_on || hi_on);
    assign reg_num = i_addr[3:0];

    always_comb begin
        o_map          = '0;
        o_map.rd_src   = SRC_RAM;
        o_map.loc_sel  = LOC_ZERO;
        o_map.ram_addr = i_addr;
        o_map.wr_ram   = 1'b1;
        o_map.wr_color = 1'b0;
        if (i_addr[15:1] == 15'd0) begin
            o_map.rd_src  = SRC_LOCAL;
            o_map.loc_sel = i_addr[0] ? LOC_PVAL : LOC_PDIR;
        end else begin
            case (i_addr[15:13])
                3'b100: begin
                    if (roml) begin
                        o_map.rd_src = SRC_CARTL;
                        o_map.wr_ram = 1'b0;
                    end
                end
                3'b101: begin
                    if (romh) begin
                        o_map.rd_src = SRC_CARTH;
                        o_map.wr_ram = 1'b0;
                    end else if (lo_on && hi_on && i_cfg.basic_present) begin
                        o_map.rd_src = SRC_BASIC;
                    end
                end
                3'b110: begin
                    if (i_addr[12]) begin
                        if (io_on) begin
                            if (!i_addr[11]) begin
                                o_map.rd_src = SRC_RAM;
                            end else if (!i_addr[10]) begin
                                o_map.rd_src   = SRC_COLOR;
                                o_map.wr_ram   = 1'b0;
                                o_map.wr_color = 1'b1;
                            end else if (i_addr[9:8] == 2'b00) begin
                                o_map.ram_addr = {KEY_PAGE, 4'h0, reg_num};
                                if (reg_num == KREG_RAM_A || reg_num == KREG_RAM_B) begin
                                    o_map.rd_src = SRC_RAM;
                                end else begin
                                    o_map.rd_src = SRC_LOCAL;
                                    o_map.wr_ram = 1'b0;
                                    case (reg_num)
                                        KREG_COLSEL: o_map.loc_sel = LOC_COLSEL;
                                        KREG_ROWS:   o_map.loc_sel = LOC_KEYS;
                                        KREG_FLAGS:  o_map.loc_sel = LOC_FLAGS;
                                        default:     o_map.loc_sel = LOC_ZERO;
                                    endcase
                                end
                            end else if (i_addr[9:8] == 2'b01) begin
                                o_map.ram_addr = {PORT2_PAGE, 4'h0, reg_num};
                                o_map.wr_ram   = (reg_num[3:2] == 2'b00);
                                if (reg_num[3:1] == 3'b000) begin
                                    o_map.rd_src = SRC_RAM;
                                end else begin
                                    o_map.rd_src  = SRC_LOCAL;
                                    o_map.loc_sel = LOC_FF;
                                end
                            end
                        end else if (!ch_on && (lo_on || hi_on) && i_cfg.charset_present) begin
                            o_map.rd_src = SRC_CHAR;
                        end
                    end
                end
                3'b111: begin
                    if (hi_on && i_cfg.kernel_present) begin
                        o_map.rd_src = SRC_KERNEL;
                    end
                end
                default: begin
                    o_map.rd_src = SRC_RAM;
                end
            endcase
        end
    end

endmodule
